FILE: src/hdlc_frame_serializer_fcs16_core_assert.svh
// ---------------------------------------------------------------------------
// HDLC framer assertion macros
// Shared concurrent assertion forms for the framer core.
// ---------------------------------------------------------------------------
`ifndef HDLC_FRAME_SERIALIZER_FCS16_CORE_ASSERT_SVH
`define HDLC_FRAME_SERIALIZER_FCS16_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HFS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
else $error("hfs assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HFS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
else $error("hfs assertion failed");

`endif

FILE: src/hfs_pkg.sv
// ---------------------------------------------------------------------------
// HDLC framer package
// Shared codes, the job record between front and back, and the FCS-16 step.
// ---------------------------------------------------------------------------
package hfs_pkg;

	localparam logic [7:0] FLAG_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE  = 8'h7D;
	localparam logic [7:0] ESC_XOR   = 8'h20;

	localparam logic [15:0] FCS_INIT = 16'hFFFF;
	localparam logic [15:0] FCS_POLY = 16'h8408;

	localparam int QUEUE_DEPTH = 2;

	// action codes
	localparam logic [1:0] ACT_HEADER  = 2'd0;
	localparam logic [1:0] ACT_PAYLOAD = 2'd1;
	localparam logic [1:0] ACT_END     = 2'd2;

	// frame types
	localparam logic [3:0] FT_I    = 4'd0;
	localparam logic [3:0] FT_RR   = 4'd1;
	localparam logic [3:0] FT_RNR  = 4'd2;
	localparam logic [3:0] FT_REJ  = 4'd3;
	localparam logic [3:0] FT_SREJ = 4'd4;
	localparam logic [3:0] FT_UI   = 4'd5;
	localparam logic [3:0] FT_SABM = 4'd6;
	localparam logic [3:0] FT_DISC = 4'd7;
	localparam logic [3:0] FT_UA   = 4'd8;
	localparam logic [3:0] FT_CMDR = 4'd9;
	localparam logic [3:0] FT_TEST = 4'd10;

	// One queued job: up to three line bytes, each marked as escapable or raw.
	typedef struct packed {
		logic [2:0][7:0] data;
		logic [2:0]      esc;
		logic [1:0]      cnt;
		logic            err;
	} hfs_job_t;

	// One byte through the reflected CCITT CRC, LSB first.
	function automatic logic [15:0] fcs_update(input logic [15:0] fcs, input logic [7:0] b);
		logic [15:0] v;
		v = fcs ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			v = v[0] ? ((v >> 1) ^ FCS_POLY) : (v >> 1);
		end
		return v;
	endfunction

endpackage

FILE: src/hdlc_frame_serializer_fcs16_core.sv
// ---------------------------------------------------------------------------
// HDLC frame serializer with FCS-16
// Builds flagged HDLC frames with escaping and a trailing FCS-16.
// ---------------------------------------------------------------------------
//  Channel | Signals                              | Beat carries
//  --------+--------------------------------------+-------------------------------
//  s_*     | s_tvalid s_tready s_tdata s_tuser    | header, payload byte or end
//  m_*     | m_tvalid m_tready m_tdata m_tlast m_tuser | one line byte
//  cfg     | cfg_wr_en cfg_wr_data                | escape enable
//
// Output runs at one line byte per cycle while m_tready holds; a job needs 1 to 5
// beats (header up to 5, payload 1 or 2, end up to 5, type error 1), paced by the
// single output register. The front accepts one beat per cycle unless the queue is
// full or the control byte of a supported header is being folded into the FCS.
// A two-entry job queue lets the front keep accepting while the output is stalled.
// Reset (arst_n low) closes any frame, empties the queue and sets escaping on.
// ---------------------------------------------------------------------------
module hdlc_frame_serializer_fcs16_core #(
	parameter int QueueDepth = hfs_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [3:0] frame_type, [11:4] station_address, [14:12] send_seq,
	// [17:15] recv_seq, [18] poll_final, [26:19] payload_byte, [31:27] zero
	input  logic [31:0] s_tdata,
	// [1:0] action
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] out_byte
	output logic [7:0]  m_tdata,
	// last_of_run
	output logic        m_tlast,
	// [0] type_error
	output logic        m_tuser,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data
);
	import hfs_pkg::*;

	localparam int JobW = $bits(hfs_job_t);

	logic     escape_enable_q;
	logic     job_push;
	hfs_job_t job_wr;
	logic     queue_full;
	logic     job_pop;
	hfs_job_t job_rd;
	logic     job_avail;

	// Escape setting; the user must change it only while the block is idle, unenforced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_enable_q <= 1'b1;
		end else if (cfg_wr_en) begin
			escape_enable_q <= cfg_wr_data;
		end
	end

	// Classify each beat, advance frame state and FCS, queue the line bytes.
	hfs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.job_push   (job_push),
		.job_data   (job_wr),
		.queue_full (queue_full)
	);

	// Decouple the two sides so either can stall on its own.
	hfs_job_queue #(
		.Width (JobW),
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job_wr),
		.full      (queue_full),
		.pop       (job_pop),
		.pop_data  (job_rd),
		.not_empty (job_avail)
	);

	// Emit queued bytes, inserting escape prefixes where needed.
	hfs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.escape_enable (escape_enable_q),
		.job_avail     (job_avail),
		.job_in        (job_rd),
		.job_pop       (job_pop),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.m_tuser       (m_tuser)
	);

`include "hdlc_frame_serializer_fcs16_core_assert.svh"

	// A type error is always a single-beat run.
	`HFS_ASSERT_NOW(a_err_is_last, clk, arst_n, m_tvalid && m_tuser, m_tlast)
	// With escaping on, an escape prefix is never the end of a run.
	`HFS_ASSERT_NOW(a_esc_not_last, clk, arst_n, m_tvalid && escape_enable_q && m_tdata == ESC_BYTE, !m_tlast)
	// The front never pushes into a full queue.
	`HFS_ASSERT_NOW(a_no_overflow, clk, arst_n, job_push, !queue_full)
	// A pop without a push from a full queue leaves it not full in the next cycle.
	`HFS_ASSERT_NEXT(a_pop_leaves_room, clk, arst_n, job_pop && !job_push && queue_full, !queue_full)

endmodule

FILE: src/hfs_job_queue.sv
// ---------------------------------------------------------------------------
// HDLC framer job queue
// Small register FIFO that decouples the classifier from the line emitter.
// ---------------------------------------------------------------------------
module hfs_job_queue #(
	parameter int Width = 8,
	parameter int Depth = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [Width-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [Width-1:0] pop_data,
	output logic             not_empty
);
	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	logic [Width-1:0] mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;

	assign full      = (count_q == CntW'(Depth));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/hfs_front.sv
// ---------------------------------------------------------------------------
// HDLC framer front end
// Accept input beats, track frame state and FCS, queue line-byte jobs.
// ---------------------------------------------------------------------------
module hfs_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,
	input  logic [1:0]       s_tuser,
	output logic             job_push,
	output hfs_pkg::hfs_job_t job_data,
	input  logic             queue_full
);
	import hfs_pkg::*;

	logic [1:0]  action;
	logic [3:0]  frame_type;
	logic [7:0]  station_address;
	logic [2:0]  send_seq;
	logic [2:0]  recv_seq;
	logic        poll_final;
	logic [7:0]  payload_byte;

	logic        frame_open_q;
	logic        payload_allowed_q;
	logic [15:0] fcs_q;
	logic        fold_q;
	logic [7:0]  pend_ctrl_q;

	logic        accept;
	logic        supported;
	logic        allow;
	logic [7:0]  ctrl;
	logic [15:0] fcs_out;

	assign action          = s_tuser;
	assign frame_type      = s_tdata[3:0];
	assign station_address = s_tdata[11:4];
	assign send_seq        = s_tdata[14:12];
	assign recv_seq        = s_tdata[17:15];
	assign poll_final      = s_tdata[18];
	assign payload_byte    = s_tdata[26:19];

	// hold input while the control byte is folded into the FCS or the queue is full
	assign s_tready = !fold_q && !queue_full;
	assign accept   = s_tvalid && s_tready;
	assign fcs_out  = ~fcs_q;

	always_comb begin
		supported = 1'b1;
		allow     = 1'b0;
		ctrl      = 8'h00;
		unique case (frame_type)
			FT_I: begin
				ctrl  = {recv_seq, 1'b0, send_seq, 1'b0};
				allow = 1'b1;
			end
			FT_RR:   ctrl = {recv_seq, 5'h01};
			FT_RNR:  ctrl = {recv_seq, 5'h05};
			FT_REJ:  ctrl = {recv_seq, 5'h09};
			FT_SREJ: ctrl = {recv_seq, 5'h0D};
			FT_UI: begin
				ctrl  = 8'h03;
				allow = 1'b1;
			end
			FT_SABM: ctrl = 8'h2F;
			FT_DISC: ctrl = 8'h43;
			FT_UA:   ctrl = 8'h63;
			FT_CMDR: ctrl = 8'h83;
			FT_TEST: ctrl = 8'hE3;
			default: supported = 1'b0;
		endcase
		ctrl = ctrl | {3'b000, poll_final, 4'h0};
	end

	always_comb begin
		job_push = 1'b0;
		job_data = '0;
		if (accept) begin
			unique case (action)
				ACT_HEADER: begin
					job_push = 1'b1;
					if (supported) begin
						job_data.data = {ctrl, station_address, FLAG_BYTE};
						job_data.esc  = 3'b110;
						job_data.cnt  = 2'd3;
					end else begin
						job_data.cnt = 2'd1;
						job_data.err = 1'b1;
					end
				end
				ACT_PAYLOAD: begin
					job_push      = frame_open_q && payload_allowed_q;
					job_data.data = {16'h0000, payload_byte};
					job_data.esc  = 3'b001;
					job_data.cnt  = 2'd1;
				end
				ACT_END: begin
					job_push      = frame_open_q;
					job_data.data = {FLAG_BYTE, fcs_out[15:8], fcs_out[7:0]};
					job_data.esc  = 3'b011;
					job_data.cnt  = 2'd3;
				end
				default: job_push = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_ctrl_q <= ctrl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q      <= 1'b0;
			payload_allowed_q <= 1'b0;
			fcs_q             <= FCS_INIT;
			fold_q            <= 1'b0;
		end else if (fold_q) begin
			fcs_q  <= fcs_update(fcs_q, pend_ctrl_q);
			fold_q <= 1'b0;
		end else if (accept) begin
			unique case (action)
				ACT_HEADER: begin
					frame_open_q      <= supported;
					payload_allowed_q <= supported && allow;
					fcs_q             <= supported ? fcs_update(FCS_INIT, station_address)
					                               : FCS_INIT;
					fold_q            <= supported;
				end
				ACT_PAYLOAD: begin
					if (frame_open_q && payload_allowed_q) begin
						fcs_q <= fcs_update(fcs_q, payload_byte);
					end
				end
				ACT_END: begin
					if (frame_open_q) begin
						frame_open_q      <= 1'b0;
						payload_allowed_q <= 1'b0;
						fcs_q             <= FCS_INIT;
					end
				end
				default: fold_q <= 1'b0;
			endcase
		end
	end

endmodule

FILE: src/hfs_back.sv
// ---------------------------------------------------------------------------
// HDLC framer back end
// Take jobs from the queue and emit one escaped line byte per beat.
// ---------------------------------------------------------------------------
module hfs_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              escape_enable,
	input  logic              job_avail,
	input  hfs_pkg::hfs_job_t job_in,
	output logic              job_pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic              m_tlast,
	output logic              m_tuser
);
	import hfs_pkg::*;

	hfs_job_t   job_q;
	logic       job_valid_q;
	logic [1:0] idx_q;
	logic       half_q;

	logic       m_valid_q;
	logic [7:0] m_data_q;
	logic       m_last_q;
	logic       m_err_q;

	logic [7:0] cur;
	logic       need_esc;
	logic       prefix;
	logic       step;
	logic       final_byte;
	logic       done_beat;

	assign cur        = job_q.data[idx_q];
	assign need_esc   = escape_enable && job_q.esc[idx_q] && (cur == ESC_BYTE || cur == FLAG_BYTE);
	assign prefix     = need_esc && !half_q;
	assign step       = job_valid_q && (!m_valid_q || m_tready);
	assign final_byte = (idx_q == 2'(job_q.cnt - 2'd1));
	assign done_beat  = step && !prefix && final_byte;
	assign job_pop    = job_avail && (!job_valid_q || done_beat);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;
	assign m_tuser  = m_err_q;

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job_in;
		end
		if (step) begin
			m_data_q <= prefix ? ESC_BYTE : (half_q ? (cur ^ ESC_XOR) : cur);
			m_last_q <= !prefix && final_byte;
			m_err_q  <= job_q.err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			idx_q       <= '0;
			half_q      <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			if (step) begin
				m_valid_q <= 1'b1;
				if (prefix) begin
					half_q <= 1'b1;
				end else begin
					half_q <= 1'b0;
					idx_q  <= idx_q + 2'd1;
				end
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (job_pop) begin
				job_valid_q <= 1'b1;
				idx_q       <= '0;
				half_q      <= 1'b0;
			end else if (done_beat) begin
				job_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: bench/hdlc_frame_serializer_fcs16_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// HDLC frame serializer testbench
// Streams header, payload and end beats into the framer and checks every line
// beat against a cycle-free frame predictor (flags, control byte, escaping,
// FCS-16 trailer, type errors), with random idling on both sides, a long
// output hold-off and escaping switched between phases.
// ---------------------------------------------------------------------------
module hdlc_frame_serializer_fcs16_core_test;
	import hfs_pkg::*;

	// codes the package does not name
	localparam logic [1:0] ACT_IGNORED          = 2'd3;
	localparam logic [3:0] FT_FIRST_UNSUPPORTED = 4'd11;
	localparam logic [3:0] FT_LAST_UNSUPPORTED  = 4'd15;

	typedef struct packed {
		logic [1:0] action;
		logic [3:0] ftype;
		logic [7:0] addr;
		logic [2:0] ns;
		logic [2:0] nr;
		logic       pf;
		logic [7:0] pay;
	} frame_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       err;
	} line_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_wr_data = 1'b0;

	hdlc_frame_serializer_fcs16_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predictor copy of the framer: register, frame state and running FCS.
	logic        escape_on = 1'b1;
	logic        link_open = 1'b0;
	logic        data_ok = 1'b0;
	logic [15:0] fcs_acc = FCS_INIT;

	frame_item_t pending[$];      // items waiting for the driver
	line_beat_t  line_expect[$];  // line beats predicted, oldest first
	line_beat_t  burst[6];        // beats caused by the item being predicted
	int          burst_len;

	// Run statistics and bookkeeping
	int mismatches = 0;
	int items_accepted = 0;
	int beats_checked = 0;
	int frames_closed = 0;
	int escape_pairs = 0;
	int type_errors = 0;
	int cfg_writes = 0;
	int counted = 0;

	// Idling control shared between the stimulus and the two side processes
	bit          offering = 1'b0;
	frame_item_t cur_item = '0;
	int          src_gap = 0;
	bit          src_steady = 1'b0;
	int          sink_gap = 0;
	int          sink_hold = 0;
	int          sink_block_req = 0;
	bit          sink_steady = 1'b0;

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int idle_span();
		int r;
		r = $urandom_range(99, 0);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// Reflected CCITT CRC, one data bit at a time, LSB first.
	function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] r;
		r = acc;
		for (int k = 0; k < 8; k++) begin
			if (r[0] ^ b[k])
				r = {1'b0, r[15:1]} ^ FCS_POLY;
			else
				r = {1'b0, r[15:1]};
		end
		return r;
	endfunction

	function automatic void put_raw(input logic [7:0] b, input logic err);
		burst[burst_len] = '{data: b, last: 1'b0, err: err};
		burst_len++;
	endfunction

	// Bytes between the flags: escape flag and escape codes when enabled.
	function automatic void put_inner(input logic [7:0] b);
		if (escape_on && (b == FLAG_BYTE || b == ESC_BYTE)) begin
			put_raw(ESC_BYTE, 1'b0);
			put_raw(b ^ ESC_XOR, 1'b0);
			escape_pairs++;
		end else begin
			put_raw(b, 1'b0);
		end
	endfunction

	// Work out the line beats of one accepted item and queue them.
	function automatic void frame_predict(input frame_item_t it);
		logic [7:0]  ctrl;
		logic [15:0] trailer;
		burst_len = 0;
		ctrl = 8'h00;
		case (it.action)
			ACT_HEADER: begin
				if (it.ftype >= FT_FIRST_UNSUPPORTED) begin
					// unsupported type: abandon any frame, report once
					link_open = 1'b0;
					data_ok = 1'b0;
					fcs_acc = FCS_INIT;
					put_raw(8'h00, 1'b1);
					type_errors++;
				end else begin
					case (it.ftype)
						FT_I:    ctrl = {it.nr, 1'b0, it.ns, 1'b0};
						FT_RR:   ctrl = {it.nr, 5'h01};
						FT_RNR:  ctrl = {it.nr, 5'h05};
						FT_REJ:  ctrl = {it.nr, 5'h09};
						FT_SREJ: ctrl = {it.nr, 5'h0D};
						FT_UI:   ctrl = 8'h03;
						FT_SABM: ctrl = 8'h2F;
						FT_DISC: ctrl = 8'h43;
						FT_UA:   ctrl = 8'h63;
						FT_CMDR: ctrl = 8'h83;
						default: ctrl = 8'hE3;
					endcase
					ctrl[4] = ctrl[4] | it.pf;
					// a header inside an open frame starts over with a fresh FCS
					link_open = 1'b1;
					data_ok = (it.ftype == FT_I) || (it.ftype == FT_UI);
					fcs_acc = crc16_fold(crc16_fold(FCS_INIT, it.addr), ctrl);
					put_raw(FLAG_BYTE, 1'b0);
					put_inner(it.addr);
					put_inner(ctrl);
				end
			end
			ACT_PAYLOAD: begin
				if (link_open && data_ok) begin
					fcs_acc = crc16_fold(fcs_acc, it.pay);
					put_inner(it.pay);
				end
			end
			ACT_END: begin
				if (link_open) begin
					trailer = ~fcs_acc;
					put_inner(trailer[7:0]);
					put_inner(trailer[15:8]);
					put_raw(FLAG_BYTE, 1'b0);
					link_open = 1'b0;
					data_ok = 1'b0;
					fcs_acc = FCS_INIT;
					frames_closed++;
				end
			end
			default: ;
		endcase
		for (int i = 0; i < burst_len; i++) begin
			burst[i].last = (i == burst_len - 1);
			line_expect.push_back(burst[i]);
		end
	endfunction

	// Sender: offer the oldest pending item, predict it on acceptance, then
	// idle for a random gap unless running steady.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (offering && s_tready) begin
				frame_predict(cur_item);
				items_accepted++;
				offering = 1'b0;
				src_gap = src_steady ? 0 : idle_span();
			end
			if (!offering) begin
				if (src_gap > 0)
					src_gap--;
				else if (pending.size() > 0) begin
					cur_item = pending.pop_front();
					offering = 1'b1;
				end
			end
			s_tvalid <= offering;
			s_tdata <= {5'b0, cur_item.pay, cur_item.pf, cur_item.nr, cur_item.ns,
				cur_item.addr, cur_item.ftype};
			s_tuser <= cur_item.action;
		end
	end

	// Receiver: long hold-off on request, otherwise random or steady ready.
	always @(posedge clk) begin
		if (sink_block_req > 0) begin
			sink_hold = sink_block_req;
			sink_block_req = 0;
		end
		if (sink_hold > 0) begin
			sink_hold--;
			m_tready <= 1'b0;
		end else if (sink_steady || sink_gap == 0) begin
			m_tready <= 1'b1;
			if (!sink_steady)
				sink_gap = idle_span();
		end else begin
			sink_gap--;
			m_tready <= 1'b0;
		end
	end

	// Monitor: compare each line beat with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (line_expect.size() == 0) begin
				$display("%0t: unexpected beat, actual byte=%02h last=%0b err=%0b",
					$time, m_tdata, m_tlast, m_tuser);
				mismatches++;
			end else begin
				beats_checked++;
				if (line_expect[0].data !== m_tdata || line_expect[0].last !== m_tlast
						|| line_expect[0].err !== m_tuser) begin
					$display("%0t: beat mismatch, expected byte=%02h last=%0b err=%0b, ",
						$time, line_expect[0].data, line_expect[0].last,
						line_expect[0].err,
						"actual byte=%02h last=%0b err=%0b", m_tdata, m_tlast, m_tuser);
					mismatches++;
				end
				void'(line_expect.pop_front());
			end
		end
	end

	function automatic frame_item_t any_item(input logic [1:0] act);
		frame_item_t it;
		it.action = act;
		it.ftype = 4'($urandom_range(15, 0));
		it.addr = 8'($urandom_range(255, 0));
		it.ns = 3'($urandom_range(7, 0));
		it.nr = 3'($urandom_range(7, 0));
		it.pf = 1'($urandom_range(1, 0));
		it.pay = 8'($urandom_range(255, 0));
		return it;
	endfunction

	task automatic push_item(input logic [1:0] act, input logic [3:0] ft, input logic [7:0] adr,
			input logic [2:0] s, input logic [2:0] r, input logic p, input logic [7:0] b);
		pending.push_back('{action: act, ftype: ft, addr: adr, ns: s, nr: r, pf: p, pay: b});
	endtask

	// Queue one frame: header, payload beats (often flag or escape codes), end if close.
	task automatic queue_frame(input logic [3:0] kind, input int body_len, input bit close);
		frame_item_t it;
		it = any_item(ACT_HEADER);
		it.ftype = kind;
		pending.push_back(it);
		repeat (body_len) begin
			it = any_item(ACT_PAYLOAD);
			if ($urandom_range(4, 0) == 0)
				it.pay = $urandom_range(1, 0) ? FLAG_BYTE : ESC_BYTE;
			pending.push_back(it);
		end
		if (close)
			pending.push_back(any_item(ACT_END));
		counted += 1 + int'(close);
		if (kind == FT_I || kind == FT_UI)
			counted += body_len;
	endtask

	// Mostly well-formed frames, some truncated ones, unsupported headers and
	// stray beats that land wherever the frame state happens to be.
	task automatic queue_mix(input int quota);
		int          target;
		int          pick;
		int          len;
		logic [3:0]  kind;
		frame_item_t it;
		target = counted + quota;
		while (counted < target) begin
			pick = $urandom_range(99, 0);
			if (pick < 80) begin
				pick = $urandom_range(99, 0);
				kind = pick < 50 ? FT_I : pick < 75 ? FT_UI : 4'($urandom_range(10, 1));
				if (kind == FT_I || kind == FT_UI)
					len = $urandom_range(9, 0) == 0 ? $urandom_range(16, 7) : $urandom_range(6, 0);
				else
					len = $urandom_range(3, 0) == 0 ? $urandom_range(2, 1) : 0;
				queue_frame(kind, len, $urandom_range(9, 0) != 0);
			end else if (pick < 88) begin
				it = any_item(ACT_HEADER);
				it.ftype = 4'($urandom_range(FT_LAST_UNSUPPORTED, FT_FIRST_UNSUPPORTED));
				pending.push_back(it);
				counted++;
			end else begin
				pending.push_back(any_item(2'($urandom_range(ACT_IGNORED, ACT_PAYLOAD))));
			end
		end
	endtask

	// Wait until every item went in and every predicted beat came out, then
	// let the block finish any item that produces nothing.
	task automatic settle();
		while (pending.size() != 0 || offering || line_expect.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_escape(input logic enable);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= enable;
		escape_on = enable;
		cfg_writes++;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		logic [15:0] trailer;
		int          found;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: escaping on from reset.
		// Smallest I frame, then payload extremes and both special bytes.
		push_item(ACT_HEADER, FT_I, 8'h00, 3'd0, 3'd0, 1'b0, 8'h00);
		push_item(ACT_PAYLOAD, FT_I, 8'h00, 3'd0, 3'd0, 1'b0, 8'h00);
		push_item(ACT_PAYLOAD, FT_I, 8'hFF, 3'd7, 3'd7, 1'b1, 8'hFF);
		push_item(ACT_PAYLOAD, FT_I, 8'h00, 3'd0, 3'd0, 1'b0, FLAG_BYTE);
		push_item(ACT_PAYLOAD, FT_I, 8'h00, 3'd0, 3'd0, 1'b0, ESC_BYTE);
		push_item(ACT_END, FT_I, 8'h00, 3'd0, 3'd0, 1'b0, 8'h00);
		// Escaped address and an I control byte that equals the flag
		push_item(ACT_HEADER, FT_I, ESC_BYTE, 3'd7, 3'd3, 1'b1, 8'hFF);
		push_item(ACT_END, FT_I, 8'hFF, 3'd7, 3'd7, 1'b1, 8'hFF);
		// Flag as address, SREJ control equal to the escape code, dropped payload
		push_item(ACT_HEADER, FT_SREJ, FLAG_BYTE, 3'd0, 3'd3, 1'b1, 8'h00);
		push_item(ACT_PAYLOAD, FT_SREJ, 8'h00, 3'd0, 3'd0, 1'b0, 8'h55);
		push_item(ACT_END, FT_SREJ, 8'h00, 3'd0, 3'd0, 1'b0, 8'h00);
		// Every other supported type, each header abandoning the one before
		push_item(ACT_HEADER, FT_RR, 8'h01, 3'd0, 3'd7, 1'b0, 8'h00);
		push_item(ACT_HEADER, FT_RNR, 8'h80, 3'd0, 3'd5, 1'b1, 8'h00);
		push_item(ACT_HEADER, FT_REJ, 8'h42, 3'd0, 3'd1, 1'b0, 8'h00);
		push_item(ACT_HEADER, FT_UI, 8'hC3, 3'd5, 3'd2, 1'b1, 8'h00);
		push_item(ACT_HEADER, FT_SABM, 8'h03, 3'd0, 3'd0, 1'b0, 8'h00);
		push_item(ACT_HEADER, FT_DISC, 8'h03, 3'd0, 3'd0, 1'b1, 8'h00);
		push_item(ACT_HEADER, FT_UA, 8'h01, 3'd0, 3'd0, 1'b0, 8'h00);
		push_item(ACT_HEADER, FT_CMDR, 8'h01, 3'd0, 3'd0, 1'b1, 8'h00);
		push_item(ACT_HEADER, FT_TEST, 8'hFE, 3'd0, 3'd0, 1'b0, 8'h00);
		// Unsupported types drop the open frame; then stray beats outside a frame
		push_item(ACT_HEADER, FT_FIRST_UNSUPPORTED, 8'h11, 3'd0, 3'd0, 1'b0, 8'h00);
		push_item(ACT_HEADER, FT_LAST_UNSUPPORTED, 8'h22, 3'd0, 3'd0, 1'b1, 8'h00);
		push_item(ACT_PAYLOAD, FT_I, 8'h00, 3'd0, 3'd0, 1'b0, 8'hA5);
		push_item(ACT_END, FT_I, 8'h00, 3'd0, 3'd0, 1'b0, 8'h00);
		push_item(ACT_IGNORED, FT_I, 8'hFF, 3'd7, 3'd7, 1'b1, 8'hFF);
		settle();

		// Phase 1: raw bytes, random idling on both sides.
		set_escape(1'b0);
		queue_mix(60);
		settle();

		// Phase 2: escaping back on; add UI frames whose FCS holds a special byte.
		set_escape(1'b1);
		found = 0;
		for (int a = 0; a < 256 && found < 4; a++) begin
			trailer = ~crc16_fold(crc16_fold(FCS_INIT, 8'(a)), 8'h03);
			if (trailer[7:0] == FLAG_BYTE || trailer[7:0] == ESC_BYTE
					|| trailer[15:8] == FLAG_BYTE || trailer[15:8] == ESC_BYTE) begin
				push_item(ACT_HEADER, FT_UI, 8'(a), 3'd0, 3'd0, 1'b0, 8'h00);
				push_item(ACT_END, FT_UI, 8'h00, 3'd0, 3'd0, 1'b0, 8'h00);
				found++;
			end
		end
		queue_mix(60);
		settle();

		// Phase 3: raw again, no idling at all.
		set_escape(1'b0);
		src_steady = 1'b1;
		sink_steady = 1'b1;
		queue_mix(60);
		settle();

		// Phase 4: hold the output off for a long stretch while the sender keeps
		// offering, so the job queue fills and the input stalls.
		set_escape(1'b1);
		sink_steady = 1'b0;
		sink_block_req = 300;
		queue_mix(60);
		settle();

		// Phase 5: raw, random idling on both sides.
		set_escape(1'b0);
		src_steady = 1'b0;
		queue_mix(60);
		settle();

		// Phase 6: escaping on, receiver always ready, sender idling.
		set_escape(1'b1);
		sink_steady = 1'b1;
		queue_mix(60);
		settle();

		$display("summary: %0d items in, %0d line beats checked, %0d frames closed",
			items_accepted, beats_checked, frames_closed);
		$display("summary: %0d escape pairs, %0d type errors, %0d escape setting writes",
			escape_pairs, type_errors, cfg_writes);
		if (mismatches == 0 && line_expect.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#10_000_000;
		$display("%0t: timeout, %0d beats still expected", $time, line_expect.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
